>>> rtl/hsc_pkg.sv
// ---------------------------------------------------------------------------
// hsc_pkg
// Shared widths, reset values, codes and controller-datapath structs for the
// homography sanity check.
// ---------------------------------------------------------------------------
`default_nettype none

package hsc_pkg;

    localparam int MAT_N   = 9;   // matrix entries
    localparam int CRN_N   = 4;   // reference corners
    localparam int VAL_W   = 32;  // Q16.16 word
    localparam int FRM_W   = 13;  // frame size registers
    localparam int DLIM_W  = 10;  // determinant limit register
    localparam int AREA_W  = 16;  // minimum area register
    localparam int NUM_W   = 50;  // projective numerator and denominator
    localparam int OPD_W   = 33;  // multiplier operand
    localparam int PRD_W   = 66;  // multiplier product
    localparam int ACC_W   = 68;  // accumulator, holds cross products exactly
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 16;
    localparam int DIV_STEPS = 31;

    localparam logic [FRM_W-1:0]  RST_FRAME_W   = 13'd640;
    localparam logic [FRM_W-1:0]  RST_FRAME_H   = 13'd480;
    localparam logic [DLIM_W-1:0] RST_DET_LIMIT = 10'd10;
    localparam logic [AREA_W-1:0] RST_MIN_AREA  = 16'd400;

    typedef enum logic [CFG_IW-1:0] {
        CFG_FRAME_W,
        CFG_FRAME_H,
        CFG_DET_LIMIT,
        CFG_MIN_AREA
    } cfg_idx_t;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_H0X,
        MS_H1Y,
        MS_H3X,
        MS_H4Y,
        MS_H6X,
        MS_H7Y,
        MS_DET0,
        MS_DET1,
        MS_CRA,
        MS_CRB,
        MS_AREA
    } mul_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_H2,
        ACC_LOAD_H5,
        ACC_LOAD_H8,
        ACC_ADD_SHIFT,
        ACC_LOAD_P,
        ACC_SUB_P
    } acc_op_t;

    typedef struct packed {
        logic     store;      // write the accepted word into the stores
        logic     start_eval; // clear matrix marks and the area sum
        logic     zero;       // missing entries: zero corners, fail
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     save_w;
        logic     div_start;
        logic     wp_wr;
        logic     wp_y;
        logic     det_chk;
        logic     cr_rec;
        logic     fin;
        logic [1:0] sel;      // corner, cross product or result number
    } hsc_cmd_t;

    typedef struct packed {
        logic all_loaded;
        logic div_done;
    } hsc_status_t;

endpackage

`default_nettype wire

>>> rtl/hsc_ifs.sv
// ---------------------------------------------------------------------------
// hsc channel interfaces
// Item, result and configuration channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface hsc_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [3:0]  index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic        evaluate;

    modport source (output valid, kind, index, value_a, value_b, evaluate, input ready);
    modport sink   (input valid, kind, index, value_a, value_b, evaluate, output ready);
endinterface

interface hsc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  corner_number;
    logic signed [31:0] warped_x;
    logic signed [31:0] warped_y;
    logic        valid_res;
    logic        last_result;

    modport source (output valid, corner_number, warped_x, warped_y, valid_res,
                    last_result, input ready);
    modport sink   (input valid, corner_number, warped_x, warped_y, valid_res,
                    last_result, output ready);
endinterface

interface hsc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/hsc_div.sv
// ---------------------------------------------------------------------------
// hsc_div
// Signed Q16.16 divider, restoring, one quotient bit per cycle, truncating
// toward zero and saturating to 32 bits. A zero divisor gives zero.
// ---------------------------------------------------------------------------
`default_nettype none

module hsc_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic signed [hsc_pkg::NUM_W-1:0] num,
    input  wire logic signed [hsc_pkg::NUM_W-1:0] den,
    output logic                               done,
    output logic signed [31:0]                 quo
);

    localparam int NW = hsc_pkg::NUM_W;
    localparam int DIV_STEPS_C = hsc_pkg::DIV_STEPS;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic [NW:0]     rem_reg, rem_next;
    logic [NW-1:0]   d_reg, d_next;
    logic [30:0]     sh_reg, sh_next;
    logic [30:0]     q_reg, q_next;
    logic            neg_reg, neg_next;
    logic [31:0]     quo_reg, quo_next;

    logic [NW-1:0]   n_mag, d_mag;
    logic            sat;
    logic [NW:0]     r2;
    logic            ge;
    logic [30:0]     q_step;

    assign n_mag  = num[NW-1] ? (~num + 1'b1) : num;
    assign d_mag  = den[NW-1] ? (~den + 1'b1) : den;
    // The integer part reaches 2^15 exactly when n >= d * 2^15.
    assign sat    = {15'b0, n_mag} >= {d_mag, 15'b0};
    assign r2     = {rem_reg[NW-1:0], sh_reg[30]};
    assign ge     = r2 >= {1'b0, d_reg};
    assign q_step = {q_reg[29:0], ge};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        sh_next   = sh_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            neg_next = num[NW-1] ^ den[NW-1];
            d_next   = d_mag;
            if (den == '0)
            begin
                quo_next  = '0;
                done_next = 1'b1;
            end
            else if (sat)
            begin
                quo_next  = (num[NW-1] ^ den[NW-1]) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                done_next = 1'b1;
            end
            else
            begin
                // Remainder starts as the dividend bits above the 31 quotient bits.
                rem_next  = {16'b0, n_mag[NW-1:15]};
                sh_next   = {n_mag[14:0], 16'b0};
                q_next    = '0;
                cnt_next  = 5'(DIV_STEPS_C);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (r2 - {1'b0, d_reg}) : r2;
            q_next   = q_step;
            sh_next  = {sh_reg[29:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                quo_next  = neg_reg ? (~{1'b0, q_step} + 1'b1) : {1'b0, q_step};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        d_reg   <= d_next;
        sh_reg  <= sh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

>>> rtl/hsc_dp.sv
// ---------------------------------------------------------------------------
// hsc_dp
// Datapath: matrix and corner stores, configuration registers, one shared
// 33x33 multiplier, accumulator, divider and the check logic.
// ---------------------------------------------------------------------------
`default_nettype none

module hsc_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire hsc_pkg::hsc_cmd_t    cmd,
    output hsc_pkg::hsc_status_t      status,
    input  wire logic                 kind,
    input  wire logic [3:0]           index,
    input  wire logic signed [31:0]   value_a,
    input  wire logic signed [31:0]   value_b,
    input  wire logic                 cfg_wr,
    input  wire logic [hsc_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [hsc_pkg::CFG_DW-1:0] cfg_data,
    output logic signed [31:0]        res_x,
    output logic signed [31:0]        res_y,
    output logic                      res_ok
);

    localparam int PW = hsc_pkg::PRD_W;
    localparam int AW = hsc_pkg::ACC_W;
    localparam int NW = hsc_pkg::NUM_W;
    localparam int FW = hsc_pkg::FRM_W;
    localparam int DW = hsc_pkg::DLIM_W;

    localparam logic [FW-1:0] RST_FW = hsc_pkg::RST_FRAME_W;
    localparam logic [FW-1:0] RST_FH = hsc_pkg::RST_FRAME_H;
    localparam logic [DW-1:0] RST_DL = hsc_pkg::RST_DET_LIMIT;
    localparam logic [hsc_pkg::AREA_W-1:0] RST_MA = hsc_pkg::RST_MIN_AREA;

    logic [FW-1:0]  frame_w_reg, frame_h_reg;
    logic [DW-1:0]  det_limit_reg;
    logic [hsc_pkg::AREA_W-1:0] min_area_reg;
    logic [hsc_pkg::MAT_N-1:0]  mmark_reg;
    logic [hsc_pkg::CRN_N-1:0]  cmark_reg;

    logic signed [31:0] mat_reg [hsc_pkg::MAT_N];
    logic signed [31:0] crx_reg [hsc_pkg::CRN_N];
    logic signed [31:0] cry_reg [hsc_pkg::CRN_N];
    logic signed [31:0] wpx_reg [hsc_pkg::CRN_N];
    logic signed [31:0] wpy_reg [hsc_pkg::CRN_N];

    logic signed [PW-1:0] p_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [NW-1:0] w_reg;
    logic [AW-1:0]        sum_reg;
    logic [3:0]           pos_reg, neg_reg;
    logic                 det_ok_reg, ok_reg;

    logic signed [hsc_pkg::OPD_W-1:0] op_a, op_b;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] p_sh;
    logic [1:0]           k1, k2;
    logic [AW-1:0]        acc_mag;
    logic                 acc_pos, acc_neg;
    logic [DW-1:0]        lim;
    logic [DW+31:0]       low_prod;
    logic                 det_ok;
    logic                 bounds_ok, convex_ok, area_ok;
    logic                 div_done;
    logic signed [31:0]   div_quo;

    function automatic logic [hsc_pkg::OPD_W-1:0] sx(input logic [31:0] v);
        return {v[31], v};
    endfunction

    function automatic logic in_frame(input logic [31:0] v, input logic [FW-1:0] s);
        logic signed [33:0] v34;
        logic signed [33:0] b;
        v34 = {{2{v[31]}}, v};
        b   = {5'b0, s, 16'b0};
        return !(v34 < -b) && !(v34 > (b <<< 1));
    endfunction

    assign k1 = cmd.sel + 2'd1;
    assign k2 = cmd.sel + 2'd2;

    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_sel)
            hsc_pkg::MS_H0X:  begin op_a = sx(mat_reg[0]); op_b = sx(crx_reg[cmd.sel]); end
            hsc_pkg::MS_H1Y:  begin op_a = sx(mat_reg[1]); op_b = sx(cry_reg[cmd.sel]); end
            hsc_pkg::MS_H3X:  begin op_a = sx(mat_reg[3]); op_b = sx(crx_reg[cmd.sel]); end
            hsc_pkg::MS_H4Y:  begin op_a = sx(mat_reg[4]); op_b = sx(cry_reg[cmd.sel]); end
            hsc_pkg::MS_H6X:  begin op_a = sx(mat_reg[6]); op_b = sx(crx_reg[cmd.sel]); end
            hsc_pkg::MS_H7Y:  begin op_a = sx(mat_reg[7]); op_b = sx(cry_reg[cmd.sel]); end
            hsc_pkg::MS_DET0: begin op_a = sx(mat_reg[0]); op_b = sx(mat_reg[4]); end
            hsc_pkg::MS_DET1: begin op_a = sx(mat_reg[3]); op_b = sx(mat_reg[1]); end
            hsc_pkg::MS_CRA:
            begin
                op_a = sx(wpx_reg[k1]) - sx(wpx_reg[cmd.sel]);
                op_b = sx(wpy_reg[k2]) - sx(wpy_reg[cmd.sel]);
            end
            hsc_pkg::MS_CRB:
            begin
                op_a = sx(wpy_reg[k1]) - sx(wpy_reg[cmd.sel]);
                op_b = sx(wpx_reg[k2]) - sx(wpx_reg[cmd.sel]);
            end
            hsc_pkg::MS_AREA: begin op_a = {20'b0, frame_w_reg}; op_b = {20'b0, frame_h_reg}; end
            default: ;
        endcase
    end

    assign prod = op_a * op_b;
    // Products are Q32.32; the shift floors them back to Q16.16.
    assign p_sh = p_reg >>> 16;

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.acc_op)
            hsc_pkg::ACC_LOAD_H2:   acc_next = {{(AW-32){mat_reg[2][31]}}, mat_reg[2]};
            hsc_pkg::ACC_LOAD_H5:   acc_next = {{(AW-32){mat_reg[5][31]}}, mat_reg[5]};
            hsc_pkg::ACC_LOAD_H8:   acc_next = {{(AW-32){mat_reg[8][31]}}, mat_reg[8]};
            hsc_pkg::ACC_ADD_SHIFT: acc_next = acc_reg + {{(AW-PW){p_sh[PW-1]}}, p_sh};
            hsc_pkg::ACC_LOAD_P:    acc_next = {{(AW-PW){p_reg[PW-1]}}, p_reg};
            hsc_pkg::ACC_SUB_P:     acc_next = acc_reg - {{(AW-PW){p_reg[PW-1]}}, p_reg};
            default: ;
        endcase
    end

    assign acc_neg = acc_reg[AW-1];
    assign acc_pos = !acc_reg[AW-1] && (acc_reg != '0);
    assign acc_mag = acc_reg[AW-1] ? (~acc_reg + 1'b1) : acc_reg;

    // |det| >= ceil(2^32/L) is the same as |det| * L >= 2^32.
    assign lim      = (det_limit_reg == '0) ? DW'(1) : det_limit_reg;
    assign low_prod = acc_mag[31:0] * lim;
    assign det_ok   = !((acc_mag[AW-1:32] == '0) && (low_prod[DW+31:32] == '0))
                      && !(acc_mag > {{(AW-DW-32){1'b0}}, lim, 32'b0});

    always_comb
    begin
        bounds_ok = 1'b1;
        for (int i = 0; i < hsc_pkg::CRN_N; i++)
        begin
            if (!in_frame(wpx_reg[i], frame_w_reg) || !in_frame(wpy_reg[i], frame_h_reg))
            begin
                bounds_ok = 1'b0;
            end
        end
    end

    assign convex_ok = (&pos_reg) || (&neg_reg);
    assign area_ok   = !(sum_reg < {19'b0, min_area_reg, 33'b0})
                       && !(sum_reg > {8'b0, p_reg[25:0], 34'b0});

    hsc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (acc_reg[NW-1:0]),
        .den   (w_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg   <= RST_FW;
            frame_h_reg   <= RST_FH;
            det_limit_reg <= RST_DL;
            min_area_reg  <= RST_MA;
            mmark_reg     <= '0;
            cmark_reg     <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (hsc_pkg::cfg_idx_t'(cfg_index))
                    hsc_pkg::CFG_FRAME_W:   frame_w_reg   <= cfg_data[FW-1:0];
                    hsc_pkg::CFG_FRAME_H:   frame_h_reg   <= cfg_data[FW-1:0];
                    hsc_pkg::CFG_DET_LIMIT: det_limit_reg <= cfg_data[DW-1:0];
                    hsc_pkg::CFG_MIN_AREA:  min_area_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.store && !kind && (index < 4'd9))
            begin
                mmark_reg[index] <= 1'b1;
            end
            if (cmd.store && kind && (index < 4'd4))
            begin
                cmark_reg[index[1:0]] <= 1'b1;
            end
            if (cmd.start_eval)
            begin
                mmark_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && !kind && (index < 4'd9))
        begin
            mat_reg[index] <= value_a;
        end
        if (cmd.store && kind && (index < 4'd4))
        begin
            crx_reg[index[1:0]] <= value_a;
            cry_reg[index[1:0]] <= value_b;
        end
        p_reg   <= prod;
        acc_reg <= acc_next;
        if (cmd.save_w)
        begin
            w_reg <= acc_reg[NW-1:0];
        end
        if (cmd.start_eval)
        begin
            sum_reg <= '0;
        end
        if (cmd.zero)
        begin
            for (int i = 0; i < hsc_pkg::CRN_N; i++)
            begin
                wpx_reg[i] <= '0;
                wpy_reg[i] <= '0;
            end
            ok_reg <= 1'b0;
        end
        if (cmd.wp_wr)
        begin
            if (cmd.wp_y)
            begin
                wpy_reg[cmd.sel] <= div_quo;
            end
            else
            begin
                wpx_reg[cmd.sel] <= div_quo;
            end
        end
        if (cmd.det_chk)
        begin
            det_ok_reg <= det_ok;
        end
        if (cmd.cr_rec)
        begin
            pos_reg[cmd.sel] <= acc_pos;
            neg_reg[cmd.sel] <= acc_neg;
            if (!cmd.sel[0])
            begin
                sum_reg <= sum_reg + acc_mag;
            end
        end
        if (cmd.fin)
        begin
            ok_reg <= det_ok_reg && bounds_ok && convex_ok && area_ok;
        end
    end

    assign status.all_loaded = (&mmark_reg) && (&cmark_reg);
    assign status.div_done   = div_done;

    assign res_x  = wpx_reg[cmd.sel];
    assign res_y  = wpy_reg[cmd.sel];
    assign res_ok = ok_reg;

endmodule

`default_nettype wire

>>> rtl/hsc_ctrl.sv
// ---------------------------------------------------------------------------
// hsc_ctrl
// Controller: sequences loads, the per-corner warp, the determinant and
// convexity products, the final check and the four result words.
// ---------------------------------------------------------------------------
`default_nettype none

module hsc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_evaluate,
    output logic                      in_ready,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output logic                      out_last,
    input  wire hsc_pkg::hsc_status_t status,
    output hsc_pkg::hsc_cmd_t         cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_INIT, S_MULY, S_ADDY, S_SAVE, S_DIV,
        S_DET0, S_DET1, S_DET2, S_DET3,
        S_CR0, S_CR1, S_CR2, S_CR3,
        S_AREA, S_FIN, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        ROW_X,
        ROW_Y,
        ROW_W
    } row_t;

    state_t     state_reg, state_next;
    row_t       row_reg, row_next;
    logic [1:0] sel_reg, sel_next;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = sel_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_last   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (in_evaluate)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                cmd.start_eval = 1'b1;
                sel_next       = '0;
                if (!status.all_loaded)
                begin
                    cmd.zero   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    row_next   = ROW_W;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                unique case (row_reg)
                    ROW_X:   begin cmd.acc_op = hsc_pkg::ACC_LOAD_H2; cmd.mul_sel = hsc_pkg::MS_H0X; end
                    ROW_Y:   begin cmd.acc_op = hsc_pkg::ACC_LOAD_H5; cmd.mul_sel = hsc_pkg::MS_H3X; end
                    default: begin cmd.acc_op = hsc_pkg::ACC_LOAD_H8; cmd.mul_sel = hsc_pkg::MS_H6X; end
                endcase
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.acc_op = hsc_pkg::ACC_ADD_SHIFT;
                unique case (row_reg)
                    ROW_X:   cmd.mul_sel = hsc_pkg::MS_H1Y;
                    ROW_Y:   cmd.mul_sel = hsc_pkg::MS_H4Y;
                    default: cmd.mul_sel = hsc_pkg::MS_H7Y;
                endcase
                state_next = S_ADDY;
            end
            S_ADDY:
            begin
                cmd.acc_op = hsc_pkg::ACC_ADD_SHIFT;
                state_next = S_SAVE;
            end
            S_SAVE:
            begin
                if (row_reg == ROW_W)
                begin
                    cmd.save_w = 1'b1;
                    row_next   = ROW_X;
                    state_next = S_INIT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.wp_wr = 1'b1;
                    cmd.wp_y  = (row_reg == ROW_Y);
                    if (row_reg == ROW_X)
                    begin
                        row_next   = ROW_Y;
                        state_next = S_INIT;
                    end
                    else if (sel_reg == 2'd3)
                    begin
                        sel_next   = '0;
                        state_next = S_DET0;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        row_next   = ROW_W;
                        state_next = S_INIT;
                    end
                end
            end
            S_DET0:
            begin
                cmd.mul_sel = hsc_pkg::MS_DET0;
                state_next  = S_DET1;
            end
            S_DET1:
            begin
                cmd.acc_op  = hsc_pkg::ACC_LOAD_P;
                cmd.mul_sel = hsc_pkg::MS_DET1;
                state_next  = S_DET2;
            end
            S_DET2:
            begin
                cmd.acc_op = hsc_pkg::ACC_SUB_P;
                state_next = S_DET3;
            end
            S_DET3:
            begin
                cmd.det_chk = 1'b1;
                state_next  = S_CR0;
            end
            S_CR0:
            begin
                cmd.mul_sel = hsc_pkg::MS_CRA;
                state_next  = S_CR1;
            end
            S_CR1:
            begin
                cmd.acc_op  = hsc_pkg::ACC_LOAD_P;
                cmd.mul_sel = hsc_pkg::MS_CRB;
                state_next  = S_CR2;
            end
            S_CR2:
            begin
                cmd.acc_op = hsc_pkg::ACC_SUB_P;
                state_next = S_CR3;
            end
            S_CR3:
            begin
                cmd.cr_rec = 1'b1;
                sel_next   = sel_reg + 2'd1;
                state_next = (sel_reg == 2'd3) ? S_AREA : S_CR0;
            end
            S_AREA:
            begin
                cmd.mul_sel = hsc_pkg::MS_AREA;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                sel_next   = '0;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                out_valid = 1'b1;
                out_last  = (sel_reg == 2'd3);
                if (out_ready)
                begin
                    sel_next = sel_reg + 2'd1;
                    if (sel_reg == 2'd3)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= ROW_W;
            sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            sel_reg   <= sel_next;
        end
    end

    // An evaluation never produces a word in the cycle right after the request.
    a_no_early_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_evaluate) |=> !out_valid)
        else $error("result word right after evaluate request");

    // Emission stops only after the fourth word went out.
    a_four_words: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> ($past(sel_reg) == 2'd3 && $past(out_ready)))
        else $error("result burst ended early");

    // The divider finishes only while the controller waits for it.
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the wait state");

endmodule

`default_nettype wire

>>> rtl/homography_sanity_check.sv
// ---------------------------------------------------------------------------
// homography_sanity_check
// Loads a Q16.16 homography and four reference corners, warps the corners
// and checks determinant, frame bounds, convexity and area.
//
//   channel  dir  word
//   item     in   kind, index, value_a, value_b, evaluate
//   result   out  corner_number, warped_x, warped_y, valid_res, last_result
//   cfg      in   index, data (frame_width, frame_height, det_limit, min_area)
//
// Load words are taken while the block is idle. With all entries loaded, each
// corner is warped in turn: w is formed first, then x and y, each by
// multiply-accumulate steps and a bit-serial quotient. The determinant, cross
// product, area and final steps follow before the first result word. With
// entries missing, the start state alone lies between the request and the
// first word. Four result words follow; no item is taken until the last is
// accepted. Reset clears the loaded marks and restores the defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module homography_sanity_check (
    input  wire logic    clk,
    input  wire logic    rst_n,
    hsc_item_if.sink     item,
    hsc_result_if.source result,
    hsc_cfg_if.sink      cfg
);

    hsc_pkg::hsc_cmd_t    cmd;
    hsc_pkg::hsc_status_t status;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_last;
    logic signed [31:0]   res_x, res_y;
    logic                 res_ok;

    hsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (item.valid),
        .in_evaluate (item.evaluate),
        .in_ready    (in_ready),
        .out_ready   (result.ready),
        .out_valid   (out_valid),
        .out_last    (out_last),
        .status      (status),
        .cmd         (cmd)
    );

    hsc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .kind      (item.kind),
        .index     (item.index),
        .value_a   (item.value_a),
        .value_b   (item.value_b),
        .cfg_wr    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_ok    (res_ok)
    );

    assign item.ready           = in_ready;
    assign cfg.ready            = 1'b1;
    assign result.valid         = out_valid;
    assign result.corner_number = cmd.sel;
    assign result.warped_x      = res_x;
    assign result.warped_y      = res_y;
    assign result.valid_res     = res_ok;
    assign result.last_result   = out_last;

endmodule

`default_nettype wire
